FILE: rtl/miu_pkg.sv
// Package for the modular inverse unit: widths, controller states and the
// command/status structs shared by controller and datapath. No dependencies.
package miu_pkg;
    localparam int WIDTH = 63;
    localparam int CNT_W = $clog2(WIDTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RED_INIT,
        S_RED_RUN,
        S_LOOP_TEST,
        S_DIV_INIT,
        S_DIV_RUN,
        S_UPDATE,
        S_FINAL_INIT,
        S_FINAL_RUN,
        S_FINISH,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start_red;
        logic div_start_step;
        logic div_start_final;
        logic div_step;
        logic red_done;
        logic update;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic m_zero;
        logic r1_zero;
        logic div_last;
    } t_status;
endpackage

FILE: rtl/miu_datapath.sv
// Datapath of the modular inverse unit: remainders, coefficients and a shared
// restoring divider that also forms q*u1 by shift-and-add. Uses miu_pkg.
module miu_datapath
    import miu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [WIDTH-1:0] i_modulus,
    input  logic [WIDTH-1:0] i_operand,
    output t_status          o_status,
    output logic [WIDTH-1:0] o_inverse,
    output logic             o_coprime
);
    // Divider: dividend shifts out of r_dq, quotient bits shift in.
    logic [WIDTH-1:0] r_dq, n_dq;
    logic [WIDTH:0]   r_rem, n_rem;
    logic [WIDTH-1:0] r_dvs;
    logic [WIDTH-1:0] r_acc;      // accumulates u0 + q*u1
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_m, r_r0, r_r1, r_u0, r_u1;
    logic             r_neg0, r_neg1;
    logic             r_coprime;
    logic [WIDTH-1:0] r_inv;

    logic [WIDTH:0]   w_shift;
    logic [WIDTH:0]   w_diff;
    logic             w_qbit;
    logic             w_div_start;

    assign w_div_start = i_cmd.div_start_red || i_cmd.div_start_step
                         || i_cmd.div_start_final;

    always_comb begin
        w_shift = {r_rem[WIDTH-1:0], r_dq[WIDTH-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_qbit  = !w_diff[WIDTH];
        n_rem   = w_qbit ? w_diff : w_shift;
        n_dq    = {r_dq[WIDTH-2:0], w_qbit};
    end

    assign o_status.m_zero   = (r_m == '0);
    assign o_status.r1_zero  = (r_r1 == '0);
    assign o_status.div_last = (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_div_start) begin
            r_cnt <= CNT_W'(WIDTH);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m    <= i_modulus;
            r_r0   <= i_modulus;
            r_r1   <= i_operand;
            r_u0   <= '0;
            r_u1   <= WIDTH'(1);
            r_neg0 <= 1'b1;
            r_neg1 <= 1'b0;
        end
        if (w_div_start) begin
            r_rem <= '0;
            r_acc <= r_u0;
            if (i_cmd.div_start_red) begin
                r_dq  <= r_r1;
                r_dvs <= r_m;
            end else if (i_cmd.div_start_step) begin
                r_dq  <= r_r0;
                r_dvs <= r_r1;
            end else begin
                r_dq  <= r_u0;
                r_dvs <= r_m;
            end
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dq  <= n_dq;
            // Quotient bit of weight 2^(cnt-1): add u1 scaled by that weight.
            if (w_qbit)
                r_acc <= r_acc + (r_u1 << (r_cnt - CNT_W'(1)));
        end
        if (i_cmd.red_done)
            r_r1 <= r_rem[WIDTH-1:0];
        if (i_cmd.update) begin
            r_r0   <= r_r1;
            r_r1   <= r_rem[WIDTH-1:0];
            r_u0   <= r_u1;
            r_u1   <= r_acc;
            r_neg0 <= r_neg1;
            r_neg1 <= !r_neg1;
        end
        if (i_cmd.finish) begin
            if (r_m == '0 || r_r0 != WIDTH'(1)) begin
                r_coprime <= 1'b0;
                r_inv     <= '0;
            end else begin
                r_coprime <= 1'b1;
                if (r_neg0 && r_rem[WIDTH-1:0] != '0)
                    r_inv <= r_m - r_rem[WIDTH-1:0];
                else
                    r_inv <= r_rem[WIDTH-1:0];
            end
        end
    end

    assign o_inverse = r_inv;
    assign o_coprime = r_coprime;
endmodule

FILE: rtl/miu_controller.sv
// Controller of the modular inverse unit: sequences reduction, Euclid steps
// and the final reduction on the shared divider. Uses miu_pkg.
module miu_controller
    import miu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;
    logic   r_phase, n_phase;   // 0 reduction, 1 loop step, final uses own state

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            S_IDLE:       if (i_in_valid) n_state = S_CHECK;
            S_CHECK:      n_state = i_status.m_zero ? S_FINISH : S_RED_INIT;
            S_RED_INIT:   begin n_state = S_DIV_RUN; n_phase = 1'b0; end
            S_RED_RUN:    n_state = S_LOOP_TEST;
            S_LOOP_TEST:  n_state = i_status.r1_zero ? S_FINAL_INIT : S_DIV_INIT;
            S_DIV_INIT:   begin n_state = S_DIV_RUN; n_phase = 1'b1; end
            S_DIV_RUN:    if (i_status.div_last)
                              n_state = r_phase ? S_UPDATE : S_RED_RUN;
            S_UPDATE:     n_state = S_LOOP_TEST;
            S_FINAL_INIT: n_state = S_FINAL_RUN;
            S_FINAL_RUN:  if (i_status.div_last) n_state = S_FINISH;
            S_FINISH:     n_state = S_OUT;
            S_OUT:        if (i_out_ready) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE:       begin o_in_ready = 1'b1; o_cmd.load = i_in_valid; end
            S_RED_INIT:   o_cmd.div_start_red = 1'b1;
            S_RED_RUN:    o_cmd.red_done = 1'b1;
            S_DIV_INIT:   o_cmd.div_start_step = 1'b1;
            S_DIV_RUN:    o_cmd.div_step = 1'b1;
            S_FINAL_RUN:  o_cmd.div_step = 1'b1;
            S_UPDATE:     o_cmd.update = 1'b1;
            S_FINAL_INIT: o_cmd.div_start_final = 1'b1;
            S_FINISH:     o_cmd.finish = 1'b1;
            S_OUT:        o_out_valid = 1'b1;
            default:      ;
        endcase
    end
endmodule

FILE: rtl/modular_inverse_unit.sv
// Modular inverse unit: one item in, one result out, one item at a time.
// The work runs on the bit-serial divider, which produces one quotient bit per
// cycle: once for the reduction of the operand, once per Euclid step and
// once for the final reduction. The next item is taken once the result
// transfer completes. Synchronous active-low reset returns the controller
// to idle. Depends on miu_pkg, miu_controller and miu_datapath.
module modular_inverse_unit
    import miu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [2*WIDTH+1:0]   s_axis_tdata,   // modulus, operand, two zero pad bits
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [WIDTH:0]       m_axis_tdata,   // inverse, one zero pad bit
    output logic                 m_axis_tuser    // coprime
);
    t_cmd    w_cmd;
    t_status w_status;
    logic [WIDTH-1:0] w_inverse;
    logic             w_coprime;

    // The controller steps the datapath through reduction of the operand,
    // the Euclid loop with the coefficient recurrence, and the final
    // reduction of the coefficient into [0, modulus).
    miu_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    miu_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_modulus (s_axis_tdata[WIDTH-1:0]),
        .i_operand (s_axis_tdata[2*WIDTH-1:WIDTH]),
        .o_status  (w_status),
        .o_inverse (w_inverse),
        .o_coprime (w_coprime)
    );

    // The coprime flag says whether the inverse field holds a real inverse.
    assign m_axis_tdata = {1'b0, w_inverse};
    assign m_axis_tuser = w_coprime;
endmodule
